@@ hdl/sss_pkg.sv @@
`default_nettype none

package sss_pkg;

    // saturation limits per display mode
    localparam logic [13:0] INT_MAX_VALUE  = 14'd9999;
    localparam logic [13:0] FRAC_MAX_VALUE = 14'd9;

    // pattern that shows "0." on the tens position
    localparam logic [7:0] POINT_ZERO_PATTERN = 8'h01;

    // digit positions
    localparam logic [1:0] POS_TENS  = 2'd2;
    localparam logic [1:0] POS_UNITS = 2'd3;

    // request modes
    typedef enum logic {
        OP_INTEGER  = 1'b0,
        OP_FRACTION = 1'b1
    } t_op;

    // configuration register indexes
    localparam logic [1:0] CFG_DIGIT_ON_TIME    = 2'd0;
    localparam logic [1:0] CFG_FRAME_GAP        = 2'd1;
    localparam logic [1:0] CFG_TWO_DIGIT_GAP    = 2'd2;
    localparam logic [1:0] CFG_FRACTION_ON_TIME = 2'd3;

    // configuration registers as seen by the strobe sequencer
    typedef struct packed {
        logic [7:0] digit_on_time;
        logic [7:0] frame_gap;
        logic [7:0] two_digit_gap;
        logic [7:0] fraction_on_time;
    } t_cfg;

    // classified request: decimal digits, units first, and top digit index
    typedef struct packed {
        t_op             op;
        logic [3:0][3:0] digits;
        logic [1:0]      top_idx;
    } t_req;

    // one strobe of the display
    typedef struct packed {
        logic [1:0] digit_select;
        logic [7:0] segments;
        logic [8:0] dwell;
        logic       last;
    } t_strobe;

    // segment pattern of one decimal digit
    function automatic logic [7:0] f_seg(input logic [3:0] digit);
        logic [7:0] pattern;
        case (digit)
            4'd0:    pattern = 8'h05;
            4'd1:    pattern = 8'h7d;
            4'd2:    pattern = 8'h46;
            4'd3:    pattern = 8'h54;
            4'd4:    pattern = 8'h3c;
            4'd5:    pattern = 8'h94;
            4'd6:    pattern = 8'h84;
            4'd7:    pattern = 8'h5d;
            4'd8:    pattern = 8'h04;
            4'd9:    pattern = 8'h14;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

@@ hdl/sss_fifo.sv @@
`default_nettype none

module sss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/sss_front.sv @@
`default_nettype none

module sss_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    output logic              o_full,
    input  wire logic         i_opcode,
    input  wire logic [13:0]  i_value,
    output logic              o_req_valid,
    output sss_pkg::t_req     o_req,
    input  wire logic         i_req_ready
);
    import sss_pkg::*;

    logic        advance;
    logic [13:0] sat_value;

    logic        r_s1_valid;
    t_op         r_s1_op;
    logic [13:0] r_s1_value;

    logic        r_s2_valid;
    t_op         r_s2_op;
    logic [3:0]  r_s2_d0;
    logic [9:0]  r_s2_q1;

    logic        r_s3_valid;
    t_op         r_s3_op;
    logic [3:0]  r_s3_d0;
    logic [3:0]  r_s3_d1;
    logic [6:0]  r_s3_q2;

    logic [29:0] prod1;
    logic [9:0]  q1;
    logic [13:0] q1_x10;
    logic [17:0] prod2;
    logic [6:0]  q2;
    logic [9:0]  q2_x10;
    logic [13:0] prod3;
    logic [3:0]  q3;
    logic [6:0]  q3_x10;
    logic [3:0]  d2;

    // whole pipeline moves together, stalls only when the last stage cannot drain
    assign advance = !r_s3_valid || i_req_ready;
    assign o_full  = !advance;

    // saturate by mode
    always_comb begin
        if (t_op'(i_opcode) == OP_FRACTION) begin
            sat_value = (i_value > FRAC_MAX_VALUE) ? FRAC_MAX_VALUE : i_value;
        end else begin
            sat_value = (i_value > INT_MAX_VALUE) ? INT_MAX_VALUE : i_value;
        end
    end

    // units digit: divide by ten through a reciprocal, exact below 43690
    assign prod1  = 30'(r_s1_value) * 30'd52429;
    assign q1     = prod1[28:19];
    assign q1_x10 = (14'(q1) << 3) + (14'(q1) << 1);

    // tens digit: reciprocal exact below 1029
    assign prod2  = 18'(r_s2_q1) * 18'd205;
    assign q2     = prod2[17:11];
    assign q2_x10 = (10'(q2) << 3) + (10'(q2) << 1);

    // hundreds and thousands digits: reciprocal exact below 179
    assign prod3  = 14'(r_s3_q2) * 14'd103;
    assign q3     = prod3[13:10];
    assign q3_x10 = (7'(q3) << 3) + (7'(q3) << 1);
    assign d2     = 4'(r_s3_q2 - q3_x10);

    // classified request out of the last stage
    always_comb begin
        o_req_valid  = r_s3_valid;
        o_req.op     = r_s3_op;
        o_req.digits = {q3, d2, r_s3_d1, r_s3_d0};
        if (q3 != 4'd0) begin
            o_req.top_idx = 2'd3;
        end else if (d2 != 4'd0) begin
            o_req.top_idx = 2'd2;
        end else if (r_s3_d1 != 4'd0) begin
            o_req.top_idx = 2'd1;
        end else begin
            o_req.top_idx = 2'd0;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_push;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_op    <= t_op'(i_opcode);
            r_s1_value <= sat_value;
            r_s2_op    <= r_s1_op;
            r_s2_d0    <= 4'(r_s1_value - q1_x10);
            r_s2_q1    <= q1;
            r_s3_op    <= r_s2_op;
            r_s3_d0    <= r_s2_d0;
            r_s3_d1    <= 4'(r_s2_q1 - q2_x10);
            r_s3_q2    <= q2;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sss_back.sv @@
`default_nettype none

module sss_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sss_pkg::t_cfg    i_cfg,
    input  wire logic             i_req_valid,
    input  wire sss_pkg::t_req    i_req,
    output logic                  o_req_pop,
    output logic                  o_stb_valid,
    output sss_pkg::t_strobe      o_stb,
    input  wire logic             i_stb_ready
);
    import sss_pkg::*;

    logic [1:0] r_k;
    logic       single;
    logic [1:0] last_k;
    logic       is_last;
    logic       fire;
    logic [3:0] cur_digit;
    logic [7:0] gap;

    // a single digit and the fraction form both take two strobes
    assign single  = (i_req.op == OP_INTEGER) && (i_req.top_idx == 2'd0);
    assign last_k  = (i_req.op == OP_FRACTION || single) ? 2'd1 : i_req.top_idx;
    assign is_last = (r_k == last_k);
    assign fire    = i_req_valid && i_stb_ready;

    assign o_stb_valid = fire;
    assign o_req_pop   = fire && is_last;

    assign cur_digit = (i_req.op == OP_FRACTION || single) ? i_req.digits[0]
                                                           : i_req.digits[r_k];
    assign gap = (i_req.top_idx == 2'd1) ? i_cfg.two_digit_gap : i_cfg.frame_gap;

    // build the current strobe
    always_comb begin
        o_stb.last     = is_last;
        o_stb.segments = f_seg(cur_digit);
        if (i_req.op == OP_FRACTION) begin
            o_stb.digit_select = (r_k == 2'd0) ? POS_TENS : POS_UNITS;
            o_stb.dwell        = {1'b0, i_cfg.fraction_on_time};
            if (r_k == 2'd0) begin
                o_stb.segments = POINT_ZERO_PATTERN;
            end
        end else if (single) begin
            o_stb.digit_select = POS_UNITS;
            o_stb.dwell = {1'b0, i_cfg.digit_on_time} + {1'b0, i_cfg.frame_gap};
        end else begin
            o_stb.digit_select = POS_UNITS - r_k;
            o_stb.dwell = {1'b0, i_cfg.digit_on_time} + (is_last ? {1'b0, gap} : 9'd0);
        end
    end

    // strobe index within the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 2'd0;
        end else if (fire) begin
            r_k <= is_last ? 2'd0 : r_k + 2'd1;
        end
    end

endmodule

`default_nettype wire

@@ hdl/seven_segment_scan_sequencer.sv @@
// Four-digit seven-segment scan sequencer.
// Request channel: push/full with i_opcode (0 integer, 1 fraction "0.d") and
// i_value; a request is taken at a clock edge with push high and full low.
// Result channel: a queue of strobes (o_digit_select, o_segments, o_dwell,
// o_last); the oldest strobe is valid while empty is low and is taken at an
// edge with pop high. Each request yields two to four strobes, o_last marks
// its final one.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high, writes belong to idle periods.
// Path: the first strobe of a request passes three digit-extraction stages,
// the queue of classified requests, the strobe sequencer and the result queue.
// Throughput: the strobe sequencer emits one strobe per cycle while the result
// queue has room, so a request holds it for two to four strobes; a request per
// cycle is taken while the queue between digit pipeline and sequencer has room.
// When the receiver stalls, the result queue fills, the sequencer holds,
// the request queue fills and full rises; nothing is lost.
// Reset clears all queues and pipeline valid bits and loads the timing
// registers with 1, 12, 20 and 5 ms.
`default_nettype none

module seven_segment_scan_sequencer #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_opcode,
    input  wire logic [13:0] i_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_digit_select,
    output logic [7:0]       o_segments,
    output logic [8:0]       o_dwell,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import sss_pkg::*;

    t_cfg    r_cfg;
    logic    req_valid;
    t_req    req_front;
    logic    mid_full;
    logic    mid_empty;
    t_req    req_head;
    logic    req_pop;
    logic    stb_valid;
    t_strobe stb_back;
    logic    out_full;
    t_strobe stb_head;

    assign o_cfg_ready = 1'b1;

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.digit_on_time    <= 8'd1;
            r_cfg.frame_gap        <= 8'd12;
            r_cfg.two_digit_gap    <= 8'd20;
            r_cfg.fraction_on_time <= 8'd5;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DIGIT_ON_TIME:    r_cfg.digit_on_time    <= i_cfg_data;
                CFG_FRAME_GAP:        r_cfg.frame_gap        <= i_cfg_data;
                CFG_TWO_DIGIT_GAP:    r_cfg.two_digit_gap    <= i_cfg_data;
                CFG_FRACTION_ON_TIME: r_cfg.fraction_on_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // digit extraction and classification
    sss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .o_req_valid (req_valid),
        .o_req       (req_front),
        .i_req_ready (!mid_full)
    );

    // queue of classified requests
    sss_fifo #(
        .WIDTH ($bits(t_req)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (req_valid),
        .i_data  (req_front),
        .o_full  (mid_full),
        .i_pop   (req_pop),
        .o_data  (req_head),
        .o_empty (mid_empty)
    );

    // strobe sequencer
    sss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (!mid_empty),
        .i_req       (req_head),
        .o_req_pop   (req_pop),
        .o_stb_valid (stb_valid),
        .o_stb       (stb_back),
        .i_stb_ready (!out_full)
    );

    // result queue
    sss_fifo #(
        .WIDTH ($bits(t_strobe)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (stb_valid),
        .i_data  (stb_back),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (stb_head),
        .o_empty (empty)
    );

    assign o_digit_select = stb_head.digit_select;
    assign o_segments     = stb_head.segments;
    assign o_dwell        = stb_head.dwell;
    assign o_last         = stb_head.last;

endmodule

`default_nettype wire

@@ hdl/sss_checker.sv @@
`default_nettype none

module sss_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  o_digit_select,
    input wire logic [7:0]  o_segments,
    input wire logic [8:0]  o_dwell,
    input wire logic        o_last
);

    // reset leaves no strobe waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // reset leaves room for a request
    a_reset_room: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full after reset");

    // the leftmost digit is only lit as the top digit of a four-digit value
    a_left_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_digit_select == 2'd0) |-> o_last)
        else $error("leftmost strobe not final");

    // dwell is at most the sum of two 8-bit times, so never 511
    a_dwell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_dwell != 9'd511))
        else $error("dwell out of range");

    // a waiting strobe holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_segments) && $stable(o_dwell)
                              && $stable(o_digit_select) && $stable(o_last)))
        else $error("waiting strobe changed");

endmodule

bind seven_segment_scan_sequencer sss_checker u_sss_checker (.*);

`default_nettype wire
